### rtl/core/permutation_counter_hash_unit_assert.svh
// ----------------------------------------------------------------------------
// permutation counter hash unit - assertion macros
// concurrent check helpers, included by the top-level rtl file that asserts
// ----------------------------------------------------------------------------
`ifndef PERMUTATION_COUNTER_HASH_UNIT_ASSERT_SVH
`define PERMUTATION_COUNTER_HASH_UNIT_ASSERT_SVH

// same-cycle implication
`define PCH_ASSERT_SAME(lbl, ck, rn, ante, cons, txt) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(txt);

// next-cycle implication
`define PCH_ASSERT_NEXT(lbl, ck, rn, ante, cons, txt) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(txt);

`endif

### rtl/core/pch_pkg.sv
// ----------------------------------------------------------------------------
// pch_pkg
// types, constants and the round function of the permutation counter hash
// ----------------------------------------------------------------------------
package pch_pkg;

  localparam int BLK_BYTES  = 184;
  localparam int HALF_BYTES = 92;
  localparam int MSG_BITS   = 1472;
  localparam int IV_POS     = 90;
  localparam int WORDS_512  = 8;
  localparam int WORDS_1024 = 16;
  localparam int RIDX_W     = 5;
  localparam int OP_W       = 3;

  typedef logic [0:383][3:0]            pst_t;
  typedef logic [0:BLK_BYTES-1][7:0]    blk_t;
  typedef logic [0:HALF_BYTES-1][7:0]   half_t;

  // hash call kinds
  localparam logic [OP_W-1:0] OP_IV   = 3'd0;
  localparam logic [OP_W-1:0] OP_CHI  = 3'd1;
  localparam logic [OP_W-1:0] OP_CLO  = 3'd2;
  localparam logic [OP_W-1:0] OP_CPAD = 3'd3;
  localparam logic [OP_W-1:0] OP_GEN  = 3'd4;
  localparam logic [OP_W-1:0] OP_S1   = 3'd5;
  localparam logic [OP_W-1:0] OP_S2   = 3'd6;

  typedef struct packed {
    logic                  acc;
    logic                  load;
    logic                  rnd;
    logic                  wb;
    logic                  shift;
    logic                  clr;
    logic [OP_W-1:0]       op;
    logic [RIDX_W-1:0]     ridx;
  } dp_cmd_t;

  typedef struct packed {
    logic start_long;
    logic blk_full;
    logic long_path;
  } dp_sts_t;

  localparam logic [3:0] SBOX [16] = '{
    4'h1, 4'h4, 4'h0, 4'hc, 4'h3, 4'h2, 4'h5, 4'hb,
    4'ha, 4'h8, 4'h6, 4'hf, 4'h7, 4'h9, 4'hd, 4'he
  };

  localparam logic [31:0] RC [28] = '{
    32'h243F6A88, 32'h85A308D3, 32'h13198A2E, 32'h03707344,
    32'hA4093822, 32'h299F31D0, 32'h082EFA98, 32'hEC4E6C89,
    32'h452821E6, 32'h38D01377, 32'hBE5466CF, 32'h34E90C6C,
    32'hC0AC29B7, 32'hC97C50DD, 32'h3F84D5B5, 32'hB5470917,
    32'h9216D5D9, 32'h8979FB1B, 32'hD1310BA6, 32'h98DFB5AC,
    32'h2FFD72DB, 32'hD01ADFB7, 32'hB8E1AFED, 32'h6A267E96,
    32'hBA7C9045, 32'hF12C7F99, 32'h24A19947, 32'hB3916CF7
  };

  localparam logic [3:0] ROWC [6] = '{4'hC, 4'h9, 4'h0, 4'h8, 4'hB, 4'h2};
  localparam int ROT [4]      = '{15, 7, 23, 16};
  localparam int MIX_DST [9]  = '{3, 4, 5, 0, 1, 2, 3, 4, 5};
  localparam int MIX_SRC [9]  = '{2, 0, 1, 3, 4, 5, 1, 2, 0};

  function automatic pst_t perm_round(pst_t s, logic [RIDX_W-1:0] r);
    pst_t a;
    logic [0:31][3:0] lh, rh, u, t;
    int k, c, row, sub;
    a = s;
    for (k = 0; k < 384; k++) a[k] = SBOX[a[k]];
    for (k = 0; k < 9; k++)
      for (c = 0; c < 64; c++) a[64*MIX_DST[k]+c] = a[64*MIX_DST[k]+c] ^ a[64*MIX_SRC[k]+c];
    for (row = 0; row < 6; row++)
      for (c = 0; c < 64; c++) a[64*row+c] = a[64*row+c] ^ ROWC[row];
    for (k = 0; k < 384; k++) a[k] = SBOX[a[k]];
    for (row = 0; row < 6; row++) begin
      lh = a[64*row +: 32];
      rh = a[64*row+32 +: 32];
      for (sub = 0; sub < 4; sub++) begin
        for (k = 0; k < 32; k++) u[k] = lh[k] ^ rh[k];
        for (k = 0; k < 32; k++) t[k] = u[(k + ROT[sub]) & 31];
        for (k = 0; k < 32; k++) begin
          lh[k] = lh[k] ^ t[k];
          u[k]  = rh[k] ^ t[k];
        end
        for (k = 0; k < 32; k++) rh[k] = u[(k + 31) & 31];
      end
      a[64*row +: 32]    = lh;
      a[64*row+32 +: 32] = rh;
    end
    for (k = 0; k < 8; k++) a[k] = a[k] ^ RC[r][31-4*k -: 4];
    return a;
  endfunction

endpackage

### rtl/core/permutation_counter_hash_unit.sv
// ----------------------------------------------------------------------------
// permutation_counter_hash_unit
// bit-exact message hash over a 1536-bit nibble permutation, digest out
// as 64-bit words
//
//   channel  dir  handshake             payload
//   in_      in   tvalid/tready         tdata: msg_byte, valid_bits; tlast
//   out_     out  tvalid/tready         tdata: digest_word; tlast
//   cfg_     in   psel/penable/pready   reg 0: digest_variant
//
// one byte beat per cycle while idle, not during a hash call or digest output
// each hash call is a load, one round per cycle, then a writeback
// a full 92-byte block holds input for one call, the 1472nd bit for three
// end of message: two final calls, then 8 or 16 output beats, held while stalled
// synchronous active-low reset, no clearing pass
// ----------------------------------------------------------------------------
`include "permutation_counter_hash_unit_assert.svh"

module permutation_counter_hash_unit #(
  parameter int ROUNDS = 28
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // msg_byte[7:0], valid_bits[11:8], zero
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // digest_word[63:0]
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic REG_VARIANT = 1'b0;

  logic              variant_r, variant_nxt;
  pch_pkg::dp_cmd_t  cmd;
  pch_pkg::dp_sts_t  sts;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_VARIANT) ? {31'd0, variant_r} : 32'd0;

  always_comb begin
    variant_nxt = variant_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
        cfg_paddr[2] == REG_VARIANT) variant_nxt = cfg_pwdata[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r <= 1'b0;
    end else begin
      variant_r <= variant_nxt;
    end
  end

  pch_ctrl #(
    .ROUNDS(ROUNDS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .variant    (variant_r),
    .sts        (sts),
    .cmd        (cmd)
  );

  pch_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_byte     (in_tdata[7:0]),
    .in_vb       (in_tdata[11:8]),
    .in_last     (in_tlast),
    .variant     (variant_r),
    .sts         (sts),
    .digest_word (out_tdata)
  );

  `PCH_ASSERT_SAME(a_out_blocks_in, clk, rst_n, out_tvalid, !in_tready, "beat taken during digest")
  `PCH_ASSERT_NEXT(a_last_starts_work, clk, rst_n, in_tvalid && in_tready && in_tlast, !in_tready, "no hash after last beat")
  `PCH_ASSERT_NEXT(a_done_to_idle, clk, rst_n, out_tvalid && out_tready && out_tlast, in_tready && !out_tvalid, "not idle after digest")

endmodule

### rtl/core/pch_ctrl.sv
// ----------------------------------------------------------------------------
// pch_ctrl
// sequencer: input acceptance, hash call order, round count, digest beats
// ----------------------------------------------------------------------------
module pch_ctrl #(
  parameter int ROUNDS = 28
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tlast,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic              out_tlast,
  input  logic              variant,
  input  pch_pkg::dp_sts_t  sts,
  output pch_pkg::dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_RND  = 3'd2;
  localparam logic [2:0] S_WB   = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]                   state_r, state_nxt;
  logic [pch_pkg::OP_W-1:0]     op_r, op_nxt;
  logic                         two_r, two_nxt;
  logic                         fin_r, fin_nxt;
  logic [pch_pkg::RIDX_W-1:0]   rnd_r, rnd_nxt;
  logic [3:0]                   wcnt_r, wcnt_nxt;
  logic                         in_acc;
  logic                         last_w;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign last_w     = variant ? (wcnt_r == 4'(pch_pkg::WORDS_1024 - 1))
                              : (wcnt_r == 4'(pch_pkg::WORDS_512 - 1));
  assign out_tvalid = (state_r == S_OUT);
  assign out_tlast  = last_w;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    two_nxt   = two_r;
    fin_nxt   = fin_r;
    rnd_nxt   = rnd_r;
    wcnt_nxt  = wcnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          fin_nxt = in_tlast;
          two_nxt = 1'b0;
          if (sts.start_long) begin
            op_nxt    = pch_pkg::OP_IV;
            two_nxt   = 1'b1;
            state_nxt = S_LOAD;
          end else if (sts.blk_full) begin
            op_nxt    = pch_pkg::OP_CHI;
            state_nxt = S_LOAD;
          end else if (in_tlast) begin
            op_nxt    = sts.long_path ? pch_pkg::OP_CPAD : pch_pkg::OP_S1;
            state_nxt = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        rnd_nxt   = '0;
        state_nxt = S_RND;
      end
      S_RND: begin
        if (rnd_r == pch_pkg::RIDX_W'(ROUNDS - 1)) begin
          state_nxt = S_WB;
        end else begin
          rnd_nxt = rnd_r + 1'b1;
        end
      end
      S_WB: begin
        state_nxt = S_LOAD;
        wcnt_nxt  = '0;
        unique case (op_r)
          pch_pkg::OP_IV:   op_nxt = pch_pkg::OP_CHI;
          pch_pkg::OP_CHI: begin
            if (two_r) begin
              op_nxt  = pch_pkg::OP_CLO;
              two_nxt = 1'b0;
            end else if (fin_r) begin
              op_nxt = pch_pkg::OP_CPAD;
            end else begin
              state_nxt = S_IDLE;
            end
          end
          pch_pkg::OP_CLO: begin
            if (fin_r) begin
              op_nxt = pch_pkg::OP_CPAD;
            end else begin
              state_nxt = S_IDLE;
            end
          end
          pch_pkg::OP_CPAD: op_nxt = pch_pkg::OP_GEN;
          pch_pkg::OP_GEN:  state_nxt = S_OUT;
          pch_pkg::OP_S1:   op_nxt = pch_pkg::OP_S2;
          pch_pkg::OP_S2:   state_nxt = S_OUT;
          default:          state_nxt = S_IDLE;
        endcase
      end
      S_OUT: begin
        if (out_tready) begin
          if (last_w) begin
            state_nxt = S_IDLE;
          end else begin
            wcnt_nxt = wcnt_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= pch_pkg::OP_IV;
      two_r   <= 1'b0;
      fin_r   <= 1'b0;
      rnd_r   <= '0;
      wcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      two_r   <= two_nxt;
      fin_r   <= fin_nxt;
      rnd_r   <= rnd_nxt;
      wcnt_r  <= wcnt_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.acc   = in_acc;
    cmd.load  = (state_r == S_LOAD);
    cmd.rnd   = (state_r == S_RND);
    cmd.wb    = (state_r == S_WB);
    cmd.shift = (state_r == S_OUT) && out_tready;
    cmd.clr   = (state_r == S_OUT) && out_tready && last_w;
    cmd.op    = op_r;
    cmd.ridx  = rnd_r;
  end

endmodule

### rtl/core/pch_dpath.sv
// ----------------------------------------------------------------------------
// pch_dpath
// message buffer, chaining value, permutation state and round unit
// ----------------------------------------------------------------------------
module pch_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  pch_pkg::dp_cmd_t  cmd,
  input  logic [7:0]        in_byte,
  input  logic [3:0]        in_vb,
  input  logic              in_last,
  input  logic              variant,
  output pch_pkg::dp_sts_t  sts,
  output logic [63:0]       digest_word
);

  pch_pkg::pst_t   st_r, st_nxt;
  pch_pkg::blk_t   chain_r, chain_nxt;
  pch_pkg::blk_t   msg_r, msg_nxt;
  logic [10:0]     bits_r, bits_nxt;
  logic [6:0]      fill_r, fill_nxt;
  logic [55:0]     blk_r, blk_nxt;
  logic            long_r, long_nxt;
  logic [7:0]      padn_r, padn_nxt;
  logic [2:0]      padt_r, padt_nxt;
  logic            var_r, var_nxt;

  logic [3:0]      vbc;
  logic [7:0]      byte_m;
  logic [2:0]      part;
  logic [10:0]     bits_sum;
  logic [6:0]      fill_inc;
  logic            start;
  logic            full;
  logic [7:0]      wr_idx;
  pch_pkg::blk_t   pad;
  pch_pkg::blk_t   y;
  pch_pkg::blk_t   x;
  pch_pkg::half_t  m;
  pch_pkg::half_t  iv;
  logic            vcur;
  logic            is_comp;
  logic [1:0]      lane_lo;
  logic [55:0]     idx;

  // input beat decode
  always_comb begin
    vbc = (in_vb > 4'd8) ? 4'd8 : in_vb;
    if (!in_last && vbc != 4'd0) vbc = 4'd8;
    byte_m   = in_byte & ~(8'hFF >> vbc);
    part     = (vbc < 4'd8) ? vbc[2:0] : 3'd0;
    bits_sum = bits_r + 11'(vbc);
    fill_inc = fill_r + 7'(vbc == 4'd8);
    start    = !long_r && vbc != 4'd0 && bits_sum >= 11'(pch_pkg::MSG_BITS);
    full     = long_r && vbc == 4'd8 && fill_inc == 7'(pch_pkg::HALF_BYTES);
    wr_idx   = long_r ? 8'(fill_r) : bits_r[10:3];
  end

  assign sts.start_long = start;
  assign sts.blk_full   = full;
  assign sts.long_path  = long_r;

  // padded message: buffered bytes, then a one bit, then zeros
  always_comb begin
    for (int i = 0; i < pch_pkg::BLK_BYTES; i++) begin
      if (8'(i) < padn_r) begin
        pad[i] = msg_r[i];
      end else if (8'(i) == padn_r) begin
        pad[i] = ((padt_r != 3'd0) ? msg_r[i] : 8'h00) | (8'h80 >> padt_r);
      end else begin
        pad[i] = 8'h00;
      end
    end
  end

  assign y           = st_r[0:367];
  assign digest_word = chain_r[0:7];
  assign vcur        = cmd.load ? variant : var_r;
  assign is_comp     = (cmd.op == pch_pkg::OP_IV) || (cmd.op == pch_pkg::OP_CHI) ||
                       (cmd.op == pch_pkg::OP_CLO) || (cmd.op == pch_pkg::OP_CPAD);

  always_comb begin
    iv = '0;
    iv[pch_pkg::IV_POS] = vcur ? 8'h04 : 8'h02;
  end

  // block selection, hash input and counter word
  always_comb begin
    case (cmd.op)
      pch_pkg::OP_IV:   m = iv;
      pch_pkg::OP_CHI:  m = msg_r[0:91];
      pch_pkg::OP_CLO:  m = msg_r[92:183];
      pch_pkg::OP_CPAD: m = pad[0:91];
      default:          m = '0;
    endcase
    case (cmd.op)
      pch_pkg::OP_IV: begin
        x       = {m, {pch_pkg::HALF_BYTES{8'h00}}};
        lane_lo = 2'd1;
        idx     = blk_r;
      end
      pch_pkg::OP_CHI, pch_pkg::OP_CLO, pch_pkg::OP_CPAD: begin
        x       = {chain_r[0:91] ^ m, chain_r[92:183]};
        lane_lo = 2'd1;
        idx     = blk_r + 56'd1;
      end
      pch_pkg::OP_GEN: begin
        x       = chain_r;
        lane_lo = 2'd2;
        idx     = 56'd1;
      end
      pch_pkg::OP_S1: begin
        x       = pad;
        lane_lo = 2'd3;
        idx     = 56'd1;
      end
      default: begin
        x       = pad;
        lane_lo = 2'd3;
        idx     = 56'd2;
      end
    endcase
  end

  always_comb begin
    st_nxt    = st_r;
    chain_nxt = chain_r;
    msg_nxt   = msg_r;
    bits_nxt  = bits_r;
    fill_nxt  = fill_r;
    blk_nxt   = blk_r;
    long_nxt  = long_r;
    padn_nxt  = padn_r;
    padt_nxt  = padt_r;
    var_nxt   = var_r;
    if (cmd.acc) begin
      if (vbc != 4'd0) begin
        msg_nxt[wr_idx] = byte_m;
        if (!long_r) begin
          bits_nxt = start ? 11'(pch_pkg::MSG_BITS) : bits_sum;
          if (start) begin
            long_nxt = 1'b1;
            fill_nxt = '0;
          end
        end else if (vbc == 4'd8) begin
          fill_nxt = full ? 7'd0 : fill_inc;
        end
      end
      if (in_last) begin
        if (start) begin
          padn_nxt = '0;
          padt_nxt = '0;
        end else if (long_r) begin
          padn_nxt = full ? 8'd0 : 8'(fill_inc);
          padt_nxt = part;
        end else begin
          padn_nxt = bits_sum[10:3];
          padt_nxt = bits_sum[2:0];
        end
      end
    end
    if (cmd.load) begin
      st_nxt  = {x, vcur, 5'd0, lane_lo, idx};
      var_nxt = variant;
      if (cmd.op == pch_pkg::OP_IV) chain_nxt = '0;
      if (is_comp && cmd.op != pch_pkg::OP_IV) blk_nxt = idx;
    end
    if (cmd.rnd) st_nxt = pch_pkg::perm_round(st_r, cmd.ridx);
    if (cmd.wb) begin
      if (is_comp) begin
        chain_nxt[0:91]   = y[0:91] ^ (var_r ? (chain_r[0:91] ^ m) : '0);
        chain_nxt[92:183] = y[92:183] ^ (var_r ? chain_r[92:183] : '0) ^ m;
      end else if (cmd.op == pch_pkg::OP_GEN) begin
        chain_nxt = y ^ (var_r ? chain_r : '0);
      end else if (cmd.op == pch_pkg::OP_S1) begin
        chain_nxt = y;
      end else begin
        chain_nxt = chain_r ^ y;
      end
    end
    if (cmd.shift) chain_nxt = {chain_r[8:183], 64'd0};
    if (cmd.clr) begin
      bits_nxt = '0;
      fill_nxt = '0;
      blk_nxt  = '0;
      long_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    st_r    <= st_nxt;
    chain_r <= chain_nxt;
    msg_r   <= msg_nxt;
    padn_r  <= padn_nxt;
    padt_r  <= padt_nxt;
    var_r   <= var_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= '0;
      fill_r <= '0;
      blk_r  <= '0;
      long_r <= 1'b0;
    end else begin
      bits_r <= bits_nxt;
      fill_r <= fill_nxt;
      blk_r  <= blk_nxt;
      long_r <= long_nxt;
    end
  end

endmodule

### verif/tb_permutation_counter_hash_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_permutation_counter_hash_unit
// streams bit-exact messages into the hash unit and compares every digest
// beat against a behavioral copy of the permutation, padding and chaining,
// with random gaps on both streams and digest variant changes between runs
// ----------------------------------------------------------------------------
module tb_permutation_counter_hash_unit;

  localparam int          N_ITEMS  = 460;
  localparam int          WDOG_MAX = 20000;
  localparam int          SETTLE   = 200;
  localparam logic [2:0]  ADDR_DIGEST_VARIANT = 3'd0;
  localparam logic        VARIANT_512  = 1'b0;
  localparam logic        VARIANT_1024 = 1'b1;

  typedef struct {
    logic [7:0] data;
    logic [3:0] vbits;
    logic       last;
  } msg_beat_t;

  typedef struct {
    logic [63:0] word;
    logic        last;
  } digest_beat_t;

  localparam logic [3:0] SUBST [16] = '{
    4'h1, 4'h4, 4'h0, 4'hc, 4'h3, 4'h2, 4'h5, 4'hb,
    4'ha, 4'h8, 4'h6, 4'hf, 4'h7, 4'h9, 4'hd, 4'he
  };
  localparam logic [31:0] RCON [28] = '{
    32'h243F6A88, 32'h85A308D3, 32'h13198A2E, 32'h03707344,
    32'hA4093822, 32'h299F31D0, 32'h082EFA98, 32'hEC4E6C89,
    32'h452821E6, 32'h38D01377, 32'hBE5466CF, 32'h34E90C6C,
    32'hC0AC29B7, 32'hC97C50DD, 32'h3F84D5B5, 32'hB5470917,
    32'h9216D5D9, 32'h8979FB1B, 32'hD1310BA6, 32'h98DFB5AC,
    32'h2FFD72DB, 32'hD01ADFB7, 32'hB8E1AFED, 32'h6A267E96,
    32'hBA7C9045, 32'hF12C7F99, 32'h24A19947, 32'hB3916CF7
  };
  localparam logic [3:0] ROW_XOR [6] = '{4'hC, 4'h9, 4'h0, 4'h8, 4'hB, 4'h2};
  localparam int         HALF_ROT [4] = '{15, 7, 23, 16};
  localparam int         MIXD [9] = '{3, 4, 5, 0, 1, 2, 3, 4, 5};
  localparam int         MIXS [9] = '{2, 0, 1, 3, 4, 5, 1, 2, 0};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  permutation_counter_hash_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  msg_beat_t    pending_q[$];
  digest_beat_t digest_q[$];
  int           n_errors = 0;
  int           n_items = 0;
  int           in_gap = 0;
  int           out_gap = 0;
  int           idle_cycles = 0;
  bit           in_taken = 1'b0;
  bit           no_idle = 1'b0;

  // hash model state
  logic        variant = VARIANT_512;
  logic [3:0]  nib [384];
  logic [7:0]  hx [184];
  logic [7:0]  hy [184];
  logic [7:0]  chain [184];
  logic [7:0]  mbuf [184];
  logic [7:0]  blk [92];
  int          bits_seen = 0;
  int          block_fill = 0;
  logic [55:0] block_idx = '0;
  bit          long_mode = 1'b0;

  function automatic void perm_one_round(int r);
    logic [3:0] lh [32];
    logic [3:0] rh [32];
    logic [3:0] u [32];
    logic [3:0] t [32];
    for (int k = 0; k < 384; k++) nib[k] = SUBST[nib[k]];
    for (int k = 0; k < 9; k++)
      for (int c = 0; c < 64; c++) nib[64*MIXD[k]+c] ^= nib[64*MIXS[k]+c];
    for (int row = 0; row < 6; row++)
      for (int c = 0; c < 64; c++) nib[64*row+c] ^= ROW_XOR[row];
    for (int k = 0; k < 384; k++) nib[k] = SUBST[nib[k]];
    for (int row = 0; row < 6; row++) begin
      for (int k = 0; k < 32; k++) begin
        lh[k] = nib[64*row+k];
        rh[k] = nib[64*row+32+k];
      end
      for (int sub = 0; sub < 4; sub++) begin
        for (int k = 0; k < 32; k++) u[k] = lh[k] ^ rh[k];
        for (int k = 0; k < 32; k++) t[k] = u[(k + HALF_ROT[sub]) % 32];
        for (int k = 0; k < 32; k++) begin
          lh[k] ^= t[k];
          u[k] = rh[k] ^ t[k];
        end
        for (int k = 0; k < 32; k++) rh[k] = u[(k + 31) % 32];
      end
      for (int k = 0; k < 32; k++) begin
        nib[64*row+k] = lh[k];
        nib[64*row+32+k] = rh[k];
      end
    end
    for (int k = 0; k < 8; k++) nib[k] ^= RCON[r][31-4*k -: 4];
  endfunction

  // hy = first 184 bytes of P(hx || lane:idx), optionally xored with hx
  function automatic void hash_call(logic [7:0] lane, logic [55:0] idx, bit feed);
    logic [63:0] ctr;
    logic [7:0]  v;
    ctr = {lane, idx};
    for (int b = 0; b < 192; b++) begin
      v = (b < 184) ? hx[b] : ctr[63-8*(b-184) -: 8];
      nib[2*b] = v[7:4];
      nib[2*b+1] = v[3:0];
    end
    for (int r = 0; r < 28; r++) perm_one_round(r);
    for (int b = 0; b < 184; b++) hy[b] = {nib[2*b], nib[2*b+1]} ^ (feed ? hx[b] : 8'h00);
  endfunction

  function automatic logic [7:0] lane_of(logic [1:0] id);
    return {variant, 5'd0, id};
  endfunction

  function automatic void compress_block();
    block_idx = block_idx + 56'd1;
    for (int k = 0; k < 92; k++) begin
      hx[k] = chain[k] ^ blk[k];
      hx[92+k] = chain[92+k];
    end
    hash_call(lane_of(2'd1), block_idx, variant);
    for (int k = 0; k < 92; k++) begin
      chain[k] = hy[k];
      chain[92+k] = hy[92+k] ^ blk[k];
    end
  endfunction

  function automatic void enter_long_path();
    logic [7:0] first [184];
    for (int k = 0; k < 184; k++) hx[k] = 8'h00;
    hx[90] = variant ? 8'h04 : 8'h02;
    hash_call(lane_of(2'd1), 56'd0, variant);
    for (int k = 0; k < 184; k++) chain[k] = hy[k];
    chain[92+90] ^= hx[90];
    for (int k = 0; k < 184; k++) first[k] = mbuf[k];
    block_idx = '0;
    for (int k = 0; k < 92; k++) blk[k] = first[k];
    compress_block();
    for (int k = 0; k < 92; k++) blk[k] = first[92+k];
    compress_block();
    block_fill = 0;
    long_mode = 1'b1;
  endfunction

  function automatic void hash_accept(msg_beat_t b);
    int          vb;
    int          part;
    int          full;
    int          tail;
    int          nwords;
    logic [7:0]  byt;
    logic [7:0]  y1 [184];
    logic [63:0] w;
    vb = (b.vbits > 8) ? 8 : int'(b.vbits);
    if (!b.last && vb > 0) vb = 8;
    byt = b.data & (8'hFF << (8 - ((vb != 0) ? vb : 8)));
    part = (vb < 8) ? vb : 0;
    if (vb > 0) begin
      if (!long_mode) begin
        mbuf[(bits_seen >> 3) % 184] = byt;
        bits_seen += vb;
        if (bits_seen >= 1472) begin
          bits_seen = 1472;
          enter_long_path();
        end
      end else begin
        mbuf[block_fill % 92] = byt;
        if (vb == 8) begin
          block_fill++;
          if (block_fill >= 92) begin
            for (int k = 0; k < 92; k++) blk[k] = mbuf[k];
            compress_block();
            block_fill = 0;
          end
        end
      end
    end
    if (!b.last) return;
    if (!long_mode) begin
      full = (bits_seen >> 3) % 184;
      tail = bits_seen & 7;
      for (int k = 0; k < 184; k++) hx[k] = (k < full) ? mbuf[k] : 8'h00;
      if (tail != 0) hx[full] = mbuf[full];
      hx[full] |= 8'h80 >> tail;
      hash_call(lane_of(2'd3), 56'd1, 1'b0);
      for (int k = 0; k < 184; k++) y1[k] = hy[k];
      hash_call(lane_of(2'd3), 56'd2, 1'b0);
      for (int k = 0; k < 184; k++) hy[k] ^= y1[k];
    end else begin
      full = block_fill % 92;
      for (int k = 0; k < 92; k++) blk[k] = (k < full) ? mbuf[k] : 8'h00;
      if (part != 0) blk[full] = mbuf[full];
      blk[full] |= 8'h80 >> part;
      compress_block();
      for (int k = 0; k < 184; k++) hx[k] = chain[k];
      hash_call(lane_of(2'd2), 56'd1, variant);
    end
    nwords = variant ? 16 : 8;
    for (int k = 0; k < nwords; k++) begin
      for (int j = 0; j < 8; j++) w[63-8*j -: 8] = hy[8*k+j];
      digest_q.push_back('{word: w, last: (k == nwords - 1)});
    end
    bits_seen = 0;
    block_fill = 0;
    block_idx = '0;
    long_mode = 1'b0;
  endfunction

  function automatic int gap_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // input driver
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        msg_beat_t b;
        b = pending_q.pop_front();
        in_tdata <= {4'd0, b.vbits, b.data};
        in_tlast <= b.last;
        in_tvalid <= 1'b1;
        in_gap = gap_len();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // digest sink stalls
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_gap = gap_len();
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      idle_cycles++;
      if (in_tvalid && in_tready) begin
        hash_accept('{data: in_tdata[7:0], vbits: in_tdata[11:8], last: in_tlast});
        in_taken = 1'b1;
        idle_cycles = 0;
      end
      if (out_tvalid && out_tready) begin
        idle_cycles = 0;
        if (digest_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("unexpected digest beat %h last %b", out_tdata, out_tlast);
        end else begin
          digest_beat_t e;
          e = digest_q.pop_front();
          if (out_tdata !== e.word || out_tlast !== e.last) begin
            n_errors++;
            if (n_errors <= 10)
              $display("digest mismatch: exp %h/%b got %h/%b",
                       e.word, e.last, out_tdata, out_tlast);
          end
        end
      end
      if (idle_cycles >= WDOG_MAX) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_q.size() > 0 || in_tvalid || digest_q.size() > 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_variant(logic v);
    wait_drained();
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_paddr = ADDR_DIGEST_VARIANT;
    cfg_pwdata = {31'd0, v};
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    variant = v;
  endtask

  task automatic push_beat(logic [7:0] d, logic [3:0] vb, logic l);
    pending_q.push_back('{data: d, vbits: vb, last: l});
    n_items++;
  endtask

  // random message; noisy adds odd valid_bits on inner beats
  task automatic push_message(int len, bit noisy);
    for (int i = 0; i < len - 1; i++)
      push_beat(8'($urandom),
                (noisy && $urandom_range(0, 9) == 0) ? 4'($urandom) : 4'd8, 1'b0);
    push_beat(8'($urandom), ($urandom_range(0, 2) == 0) ? 4'd8 : 4'($urandom), 1'b1);
  endtask

  task automatic directed_set();
    push_beat(8'h00, 4'd0, 1'b1);
    push_beat(8'hFF, 4'd1, 1'b1);
    push_beat(8'hFF, 4'd8, 1'b1);
    push_beat(8'hA5, 4'd15, 1'b1);
    push_beat(8'h3C, 4'd0, 1'b0);
    push_beat(8'hFF, 4'd5, 1'b0);
    push_beat(8'h00, 4'd12, 1'b0);
    push_beat(8'h00, 4'd7, 1'b1);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    directed_set();
    write_variant(VARIANT_1024);
    directed_set();
    // exactly 1472 bits, then one bit short of it
    push_message(1, 1'b0);
    for (int i = 0; i < 183; i++) push_beat(8'($urandom), 4'd8, 1'b0);
    push_beat(8'($urandom), 4'd8, 1'b1);
    write_variant(VARIANT_512);
    for (int i = 0; i < 183; i++) push_beat(8'($urandom), 4'd8, 1'b0);
    push_beat(8'($urandom), 4'd7, 1'b1);
    while (n_items < N_ITEMS) begin
      if ($urandom_range(0, 7) == 0) write_variant(1'($urandom_range(0, 1)));
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0)
        push_message($urandom_range(185, 290), 1'b1);
      else
        push_message($urandom_range(1, 40), 1'b1);
    end
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/pch_pkg.sv
rtl/core/pch_ctrl.sv
rtl/core/pch_dpath.sv
rtl/core/permutation_counter_hash_unit.sv
verif/tb_permutation_counter_hash_unit.sv
